FILE: rtl/speed_hysteresis_mode_switch_macros.svh
// Assertion macros for the top-level file, which checks its own logic with them.
`ifndef SPEED_HYSTERESIS_MODE_SWITCH_MACROS_SVH
`define SPEED_HYSTERESIS_MODE_SWITCH_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SHMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`define SHMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define SHMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SHMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/shms_pkg.sv
`timescale 1ns / 1ps

package shms_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int SPEED_W     = 16;
    localparam int HYST_W      = 15;
    localparam int HOLDOFF_W   = 16;
    localparam int BAND_W      = 18;

    typedef enum logic [1:0] {
        OP_SPEED    = 2'd0,
        OP_OVERRIDE = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD     = 3'd0,
        CFG_HYSTERESIS    = 3'd1,
        CFG_HOLDOFF_TICKS = 3'd2,
        CFG_SWITCH_ENABLE = 3'd3,
        CFG_HIGH_SPEED_NEG = 3'd4
    } cfg_index_t;

    localparam logic signed [SPEED_W-1:0] THRESHOLD_RST     = 16'sd512;
    localparam logic [HYST_W-1:0]         HYSTERESIS_RST    = 15'd51;
    localparam logic [HOLDOFF_W-1:0]      HOLDOFF_TICKS_RST = 16'd1000;

    typedef struct packed {
        logic signed [SPEED_W-1:0] threshold;
        logic [HYST_W-1:0]         hysteresis;
        logic [HOLDOFF_W-1:0]      holdoff_ticks;
        logic                      switch_enable;
        logic                      high_speed_negative;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic                      item_valid;
        logic signed [SPEED_W-1:0] speed_sample;
        logic                      override_negative;
    } item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_echo;
        logic                      above_flag;
        logic                      sign_negative;
        logic                      switched;
        logic                      enable_echo;
    } result_t;

endpackage

FILE: rtl/shms_cfg.sv
`timescale 1ns / 1ps

module shms_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [shms_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [shms_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output shms_pkg::cfg_t                     cfg
);
    import shms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                CFG_THRESHOLD:      cfg_next.threshold = cfg_wr_data;
                CFG_HYSTERESIS:     cfg_next.hysteresis = cfg_wr_data[HYST_W-1:0];
                CFG_HOLDOFF_TICKS:  cfg_next.holdoff_ticks = cfg_wr_data[HOLDOFF_W-1:0];
                CFG_SWITCH_ENABLE:  cfg_next.switch_enable = cfg_wr_data[0];
                CFG_HIGH_SPEED_NEG: cfg_next.high_speed_negative = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold           <= THRESHOLD_RST;
            cfg_reg.hysteresis          <= HYSTERESIS_RST;
            cfg_reg.holdoff_ticks       <= HOLDOFF_TICKS_RST;
            cfg_reg.switch_enable       <= 1'b1;
            cfg_reg.high_speed_negative <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/shms_core.sv
`timescale 1ns / 1ps

module shms_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  shms_pkg::cfg_t    cfg,
    input  shms_pkg::item_t   item,
    input  logic              fire,
    output logic              has_result,
    output shms_pkg::result_t result
);
    import shms_pkg::*;

    logic                 primed_reg, primed_next;
    logic                 above_reg, above_next;
    logic                 sign_neg_reg, sign_neg_next;
    logic [HOLDOFF_W-1:0] holdoff_reg, holdoff_next;

    logic signed [BAND_W-1:0] speed_ext;
    logic signed [BAND_W-1:0] thr_ext;
    logic signed [BAND_W-1:0] hyst_ext;
    logic signed [BAND_W-1:0] band_hi;
    logic signed [BAND_W-1:0] band_lo;
    logic                     regime;
    logic                     want_neg;
    logic                     do_switch;

    assign speed_ext = BAND_W'(item.speed_sample);
    assign thr_ext   = BAND_W'(cfg.threshold);
    assign hyst_ext  = signed'({{(BAND_W-HYST_W){1'b0}}, cfg.hysteresis});
    assign band_hi   = thr_ext + hyst_ext;
    assign band_lo   = thr_ext - hyst_ext;

    always_comb begin
        if (!primed_reg) begin
            regime = (speed_ext >= thr_ext);
        end else if (above_reg && (speed_ext < band_lo)) begin
            regime = 1'b0;
        end else if (!above_reg && (speed_ext > band_hi)) begin
            regime = 1'b1;
        end else begin
            regime = above_reg;
        end
    end

    // The sign wanted above the threshold is the configured one, below it the opposite.
    assign want_neg  = regime ? cfg.high_speed_negative : !cfg.high_speed_negative;
    assign do_switch = primed_reg && (regime != above_reg) && cfg.switch_enable
                       && (holdoff_reg == '0) && (want_neg != sign_neg_reg);

    assign has_result = item.item_valid && (op_t'(item.operation) == OP_SPEED);

    always_comb begin
        primed_next   = primed_reg;
        above_next    = above_reg;
        sign_neg_next = sign_neg_reg;
        holdoff_next  = holdoff_reg;
        if (fire && item.item_valid) begin
            case (op_t'(item.operation))
                OP_SPEED: begin
                    primed_next = 1'b1;
                    above_next  = regime;
                    if (do_switch) begin
                        sign_neg_next = want_neg;
                        holdoff_next  = cfg.holdoff_ticks;
                    end
                end
                OP_OVERRIDE: begin
                    sign_neg_next = item.override_negative;
                end
                OP_TICK: begin
                    if (holdoff_reg != '0) begin
                        holdoff_next = holdoff_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        result.speed_echo    = item.speed_sample;
        result.above_flag    = regime;
        result.sign_negative = do_switch ? want_neg : sign_neg_reg;
        result.switched      = do_switch;
        result.enable_echo   = cfg.switch_enable;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg   <= 1'b0;
            above_reg    <= 1'b0;
            sign_neg_reg <= 1'b0;
            holdoff_reg  <= '0;
        end else begin
            primed_reg   <= primed_next;
            above_reg    <= above_next;
            sign_neg_reg <= sign_neg_next;
            holdoff_reg  <= holdoff_next;
        end
    end

endmodule

FILE: rtl/speed_hysteresis_mode_switch.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// s_        in         s_valid/s_ready  operation, item_valid, speed_sample, override_negative
// m_        out        m_valid/m_ready  speed_echo, above_flag, sign_negative, switched,
//                                       enable_echo
// cfg_wr_   in         cfg_wr_en        cfg_wr_index, cfg_wr_data
//
// Every request lands in an input register and is resolved against the state when it
// leaves it; a speed request's result is then registered in the output register.
// One request is taken per cycle while s_ready is high; overrides, ticks and invalid
// requests never stall. A speed request waits in the input register only while the
// output register is full and m_ready is low. Reset is synchronous and active low.

module speed_hysteresis_mode_switch (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_operation,
    input  logic                                    s_item_valid,
    input  logic signed [shms_pkg::SPEED_W-1:0]     s_speed_sample,
    input  logic                                    s_override_negative,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [shms_pkg::SPEED_W-1:0]     m_speed_echo,
    output logic                                    m_above_flag,
    output logic                                    m_sign_negative,
    output logic                                    m_switched,
    output logic                                    m_enable_echo,
    input  logic                                    cfg_wr_en,
    input  logic [shms_pkg::CFG_INDEX_W-1:0]        cfg_wr_index,
    input  logic [shms_pkg::CFG_DATA_W-1:0]         cfg_wr_data
);
    import shms_pkg::*;

    `include "speed_hysteresis_mode_switch_macros.svh"

    cfg_t    cfg;
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    core_has_result;
    result_t core_result;
    logic    advance;

    shms_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    shms_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item       (in_item_reg),
        .fire       (advance),
        .has_result (core_has_result),
        .result     (core_result)
    );

    assign advance = in_valid_reg && (!core_has_result || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && core_has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.operation         <= s_operation;
            in_item_reg.item_valid        <= s_item_valid;
            in_item_reg.speed_sample      <= s_speed_sample;
            in_item_reg.override_negative <= s_override_negative;
        end
        if (advance && core_has_result) begin
            out_res_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_speed_echo    = out_res_reg.speed_echo;
    assign m_above_flag    = out_res_reg.above_flag;
    assign m_sign_negative = out_res_reg.sign_negative;
    assign m_switched      = out_res_reg.switched;
    assign m_enable_echo   = out_res_reg.enable_echo;

    `SHMS_ASSERT_NEXT(a_taken_request_held, aclk, aresetn, s_valid && s_ready, in_valid_reg)
    `SHMS_ASSERT_SAME(a_switch_needs_enable, aclk, aresetn, m_valid && m_switched, m_enable_echo)
    `SHMS_ASSERT_SAME(a_switch_sign_matches, aclk, aresetn, m_valid && m_switched,
        m_sign_negative == (m_above_flag == cfg.high_speed_negative))

endmodule

FILE: bench/mode_switch_checker.sv
`timescale 1ns / 1ps

module mode_switch_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic                                s_item_valid,
    input  logic signed [shms_pkg::SPEED_W-1:0] s_speed_sample,
    input  logic                                s_override_negative,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [shms_pkg::SPEED_W-1:0] m_speed_echo,
    input  logic                                m_above_flag,
    input  logic                                m_sign_negative,
    input  logic                                m_switched,
    input  logic                                m_enable_echo,
    input  logic                                cfg_wr_en,
    input  logic [shms_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [shms_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output int                                  mismatch_count,
    output int                                  pending_results
);
    import shms_pkg::*;

    localparam int REPORT_LIMIT = 10;

    cfg_t                 cfg;
    logic                 primed;
    logic                 above_regime;
    logic                 sign_negative;
    logic [HOLDOFF_W-1:0] holdoff_left;
    result_t              expected_status [$];

    initial mismatch_count = 0;
    initial pending_results = 0;

    task automatic apply_request(input logic [1:0] op, input logic item_ok,
                                 input logic signed [SPEED_W-1:0] speed,
                                 input logic override_neg);
        logic signed [BAND_W-1:0] speed_x;
        logic signed [BAND_W-1:0] thr_x;
        logic signed [BAND_W-1:0] band_hi;
        logic signed [BAND_W-1:0] band_lo;
        logic                     next_above;
        logic                     wanted;
        logic                     fired;
        result_t                  status;
        if (!item_ok) begin
            return;
        end
        case (op)
            OP_OVERRIDE: begin
                sign_negative = override_neg;
            end
            OP_TICK: begin
                if (holdoff_left != '0) begin
                    holdoff_left = holdoff_left - 1'b1;
                end
            end
            OP_SPEED: begin
                fired = 1'b0;
                speed_x = {{(BAND_W-SPEED_W){speed[SPEED_W-1]}}, speed};
                thr_x = {{(BAND_W-SPEED_W){cfg.threshold[SPEED_W-1]}}, cfg.threshold};
                band_hi = thr_x + {{(BAND_W-HYST_W){1'b0}}, cfg.hysteresis};
                band_lo = thr_x - {{(BAND_W-HYST_W){1'b0}}, cfg.hysteresis};
                if (!primed) begin
                    above_regime = (speed_x >= thr_x);
                    primed = 1'b1;
                end else begin
                    next_above = above_regime;
                    if (above_regime && speed_x < band_lo) begin
                        next_above = 1'b0;
                    end else if (!above_regime && speed_x > band_hi) begin
                        next_above = 1'b1;
                    end
                    if (next_above != above_regime && cfg.switch_enable
                            && holdoff_left == '0) begin
                        wanted = next_above ? cfg.high_speed_negative
                                            : ~cfg.high_speed_negative;
                        if (wanted != sign_negative) begin
                            sign_negative = wanted;
                            holdoff_left = cfg.holdoff_ticks;
                            fired = 1'b1;
                        end
                    end
                    above_regime = next_above;
                end
                status.speed_echo = speed;
                status.above_flag = above_regime;
                status.sign_negative = sign_negative;
                status.switched = fired;
                status.enable_echo = cfg.switch_enable;
                expected_status.push_back(status);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : monitor
        result_t seen;
        result_t want;
        logic    bad;
        if (!aresetn) begin
            cfg.threshold = THRESHOLD_RST;
            cfg.hysteresis = HYSTERESIS_RST;
            cfg.holdoff_ticks = HOLDOFF_TICKS_RST;
            cfg.switch_enable = 1'b1;
            cfg.high_speed_negative = 1'b0;
            primed = 1'b0;
            above_regime = 1'b0;
            sign_negative = 1'b0;
            holdoff_left = '0;
            expected_status.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.speed_echo = m_speed_echo;
                seen.above_flag = m_above_flag;
                seen.sign_negative = m_sign_negative;
                seen.switched = m_switched;
                seen.enable_echo = m_enable_echo;
                if (expected_status.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: status with none expected: speed %0d above %0b",
                                 $realtime, seen.speed_echo, seen.above_flag);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_status.pop_front();
                    bad = (seen.speed_echo !== want.speed_echo)
                        || (seen.above_flag !== want.above_flag)
                        || (seen.sign_negative !== want.sign_negative)
                        || (seen.switched !== want.switched)
                        || (seen.enable_echo !== want.enable_echo);
                    if (bad) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display({"%0t: status mismatch: expected speed %0d above %0b ",
                                      "neg %0b switched %0b enable %0b, got speed %0d ",
                                      "above %0b neg %0b switched %0b enable %0b"},
                                     $realtime, want.speed_echo, want.above_flag,
                                     want.sign_negative, want.switched, want.enable_echo,
                                     seen.speed_echo, seen.above_flag, seen.sign_negative,
                                     seen.switched, seen.enable_echo);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_request(s_operation, s_item_valid, s_speed_sample,
                              s_override_negative);
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_THRESHOLD: cfg.threshold = cfg_wr_data;
                    CFG_HYSTERESIS: cfg.hysteresis = cfg_wr_data[HYST_W-1:0];
                    CFG_HOLDOFF_TICKS: cfg.holdoff_ticks = cfg_wr_data;
                    CFG_SWITCH_ENABLE: cfg.switch_enable = cfg_wr_data[0];
                    CFG_HIGH_SPEED_NEG: cfg.high_speed_negative = cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
        pending_results <= expected_status.size();
    end

endmodule

FILE: bench/speed_hysteresis_mode_switch_test.sv
`timescale 1ns / 1ps

module speed_hysteresis_mode_switch_test;
    import shms_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 200;
    localparam int HOLD_AFTER      = 150;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 88;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_operation = OP_SPEED;
    logic                      s_item_valid = 1'b0;
    logic signed [SPEED_W-1:0] s_speed_sample = '0;
    logic                      s_override_negative = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [SPEED_W-1:0] m_speed_echo;
    logic                      m_above_flag;
    logic                      m_sign_negative;
    logic                      m_switched;
    logic                      m_enable_echo;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_wr_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]     cfg_wr_data = '0;

    int mismatch_count;
    int pending_results;
    int cycle_count = 0;
    int requests_sent = 0;
    bit idling = 1'b1;
    bit long_hold_done = 1'b0;
    int cur_threshold = 512;
    int cur_hysteresis = 51;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    speed_hysteresis_mode_switch dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_item_valid        (s_item_valid),
        .s_speed_sample      (s_speed_sample),
        .s_override_negative (s_override_negative),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_speed_echo        (m_speed_echo),
        .m_above_flag        (m_above_flag),
        .m_sign_negative     (m_sign_negative),
        .m_switched          (m_switched),
        .m_enable_echo       (m_enable_echo),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data)
    );

    mode_switch_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_item_valid        (s_item_valid),
        .s_speed_sample      (s_speed_sample),
        .s_override_negative (s_override_negative),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_speed_echo        (m_speed_echo),
        .m_above_flag        (m_above_flag),
        .m_sign_negative     (m_sign_negative),
        .m_switched          (m_switched),
        .m_enable_echo       (m_enable_echo),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .mismatch_count      (mismatch_count),
        .pending_results     (pending_results)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // In idling phases the receiver stalls in short random bursts, and once holds off long enough
    // for the block to fill up and push back on the sender.
    initial begin : receiver
        int burst;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && requests_sent >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idling && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 7);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic item_ok,
                                input int speed, input logic override_neg);
        int gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_operation <= op;
        s_item_valid <= item_ok;
        s_speed_sample <= speed[SPEED_W-1:0];
        s_override_negative <= override_neg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
    endtask

    // Bits above a register's width are random; the block must ignore them.
    task automatic set_config(input int thr, input int hyst, input int hold,
                              input logic enable, input logic high_neg);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_THRESHOLD, thr[CFG_DATA_W-1:0]);
        write_reg(CFG_HYSTERESIS, {junk[CFG_DATA_W-1], hyst[HYST_W-1:0]});
        write_reg(CFG_HOLDOFF_TICKS, hold[CFG_DATA_W-1:0]);
        write_reg(CFG_SWITCH_ENABLE, {junk[CFG_DATA_W-1:1], enable});
        write_reg(CFG_HIGH_SPEED_NEG, {~junk[CFG_DATA_W-1:1], high_neg});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_threshold = thr;
        cur_hysteresis = hyst;
    endtask

    function automatic int near_band();
        int v;
        v = cur_threshold - cur_hysteresis - 6
            + int'($urandom_range(0, 2 * cur_hysteresis + 12));
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v;
    endfunction

    function automatic int random_speed();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic random_phase();
        int effective;
        int pick;
        effective = 0;
        while (effective < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_request(OP_SPEED, 1'b1, near_band(), 1'($urandom_range(0, 1)));
                effective++;
            end else if (pick < 65) begin
                send_request(OP_SPEED, 1'b1, random_speed(), 1'($urandom_range(0, 1)));
                effective++;
            end else if (pick < 82) begin
                send_request(OP_TICK, 1'b1, random_speed(), 1'($urandom_range(0, 1)));
                effective++;
            end else if (pick < 89) begin
                send_request(OP_OVERRIDE, 1'b1, random_speed(), 1'($urandom_range(0, 1)));
                effective++;
            end else if (pick < 96) begin
                send_request(2'($urandom_range(0, 3)), 1'b0, random_speed(),
                             1'($urandom_range(0, 1)));
            end else begin
                send_request(2'd3, 1'b1, random_speed(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(OP_SPEED, 1'b1, 512, 1'b0);
        send_request(OP_SPEED, 1'b0, -100, 1'b1);
        send_request(2'd3, 1'b1, 777, 1'b1);
        send_request(OP_TICK, 1'b1, 0, 1'b0);
        send_request(OP_OVERRIDE, 1'b1, 0, 1'b1);
        send_request(OP_OVERRIDE, 1'b1, 0, 1'b0);
        send_request(OP_SPEED, 1'b1, 461, 1'b0);
        send_request(OP_SPEED, 1'b1, 460, 1'b0);
        send_request(OP_SPEED, 1'b1, 32767, 1'b0);
        send_request(OP_TICK, 1'b0, 0, 1'b0);
        send_request(OP_OVERRIDE, 1'b0, 0, 1'b0);
        send_request(OP_SPEED, 1'b1, -32768, 1'b0);
        drain();
        set_config(-32768, 32767, 0, 1'b1, 1'b1);
        send_request(OP_SPEED, 1'b1, 0, 1'b0);
        send_request(OP_OVERRIDE, 1'b1, 0, 1'b0);
        send_request(OP_SPEED, 1'b1, -32768, 1'b0);
        drain();
        set_config(0, 0, 0, 1'b1, 1'b1);
        send_request(OP_SPEED, 1'b1, -1, 1'b0);
        send_request(OP_SPEED, 1'b1, 1, 1'b0);
        send_request(OP_SPEED, 1'b1, -1, 1'b0);
        send_request(OP_SPEED, 1'b1, 0, 1'b0);
        drain();
        set_config(0, 0, 2, 1'b0, 1'b0);
        send_request(OP_SPEED, 1'b1, 5, 1'b0);
        send_request(OP_SPEED, 1'b1, -5, 1'b0);
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            idling = (phase % 3 != 2) && (phase != NUM_PHASES - 1);
            case (phase)
                1: set_config(32767, 32767, 65535, 1'b1, 1'b1);
                2: set_config(-32768, 0, 0, 1'b0, 1'b0);
                3: set_config(0, 0, 1, 1'b1, 1'b0);
                default: set_config(random_speed(),
                                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                                : $urandom_range(0, 200),
                                    $urandom_range(0, 12),
                                    ($urandom_range(0, 4) != 0),
                                    1'($urandom_range(0, 1)));
            endcase
            random_phase();
            drain();
        end

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
